@@ src/sbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table binary search package
// Shared sizes, result codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package sbs_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 1024;
	localparam int INDEX_W     = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = INDEX_W + 1;
	localparam int BOUND_W     = INDEX_W + 2;
	localparam int DATA_W      = 32;

	// Action codes carried by an input word.
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	// Index reported when the key is absent (minus one).
	localparam logic [COUNT_W-1:0] NOT_FOUND_INDEX = '1;

	// Saturated entry count.
	localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(TABLE_DEPTH);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // write the table entry of the accepted word
		logic start;       // capture the key and set the initial bounds
		logic read;        // read the midpoint entry
		logic step_lo;     // key is above the probed entry: low = mid + 1
		logic step_hi;     // key is below the probed entry: high = mid - 1
		logic take_found;  // capture a hit into the output register
		logic take_miss;   // capture a miss into the output register
	} sbs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic range_empty;
		logic key_eq;
		logic key_lt;
	} sbs_stat_t;

endpackage

@@ src/sorted_table_binary_search.sv @@
`timescale 1ns / 1ps
// A load word gives no result. Each probe of a search reads the midpoint entry in the probe
// state and compares it in the compare state (p probes, p at most 11 for 1024 entries); a hit
// is registered from the compare state, a miss from the probe state once the range is empty.
// The next word is taken once the controller is back in idle, so a new search waits for the last
// one to finish, and a held result stalls the hand-off.
// Reset clears the entry count and the control state; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
// Sorted table binary search
// Top level: a controller sequences probes over a RAM-backed table of
// ascending signed values held in the datapath.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
	import sbs_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [COUNT_W-1:0]        cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      action,
	input  logic [INDEX_W-1:0]        entry_index,
	input  logic signed [DATA_W-1:0]  entry_value,
	input  logic signed [DATA_W-1:0]  search_key,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	output logic signed [COUNT_W-1:0] found_index
);

	sbs_cmd_t  cmd;
	sbs_stat_t stat;

	// Sequencing and handshakes.
	sbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// Table, bounds, compare and result.
	sbs_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.search_key (search_key),
		.cmd        (cmd),
		.stat       (stat),
		.found      (found),
		.found_index(found_index)
	);

endmodule

@@ src/sbs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read; read data holds
// while no read is issued.
// ----------------------------------------------------------------------------
module sbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/sbs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary search controller
// Accepts words, sequences the read and compare of each probe, and owns the
// valid flag of the output register.
// ----------------------------------------------------------------------------
module sbs_ctrl
	import sbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      action,
	output logic      out_valid,
	input  logic      out_ready,
	output sbs_cmd_t  cmd,
	input  sbs_stat_t stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_COMPARE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_fire;
	logic   slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// The output register can take a result when empty or being drained.
	assign slot_free = !out_valid_q || out_ready;

	// Command decode.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load  = in_fire && (action == ACT_LOAD);
				cmd.start = in_fire && (action == ACT_SEARCH);
			end
			ST_PROBE: begin
				cmd.take_miss = stat.range_empty && slot_free;
				cmd.read      = !stat.range_empty;
			end
			ST_COMPARE: begin
				cmd.take_found = stat.key_eq && slot_free;
				cmd.step_hi    = !stat.key_eq && stat.key_lt;
				cmd.step_lo    = !stat.key_eq && !stat.key_lt;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take_found || cmd.take_miss) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (cmd.read) begin
						state_q <= ST_COMPARE;
					end else if (cmd.take_miss) begin
						state_q <= ST_IDLE;
					end
				end
				ST_COMPARE: begin
					if (cmd.take_found) begin
						state_q <= ST_IDLE;
					end else if (cmd.step_lo || cmd.step_hi) begin
						state_q <= ST_PROBE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/sbs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary search datapath
// Holds the entry count register, the table RAM, the search bounds and key,
// the key compare and the result register.
// ----------------------------------------------------------------------------
module sbs_datapath
	import sbs_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [COUNT_W-1:0]        cfg_data,
	input  logic [INDEX_W-1:0]        entry_index,
	input  logic signed [DATA_W-1:0]  entry_value,
	input  logic signed [DATA_W-1:0]  search_key,
	input  sbs_cmd_t                  cmd,
	output sbs_stat_t                 stat,
	output logic                      found,
	output logic signed [COUNT_W-1:0] found_index
);

	logic [COUNT_W-1:0]        count_q;
	logic [COUNT_W-1:0]        count_sat;
	logic signed [BOUND_W-1:0] lo_q;
	logic signed [BOUND_W-1:0] hi_q;
	logic signed [BOUND_W-1:0] bound_sum;
	logic [INDEX_W-1:0]        mid;
	logic [INDEX_W-1:0]        mid_q;
	logic signed [DATA_W-1:0]  key_q;
	logic [DATA_W-1:0]         rd_data;
	logic                      found_q;
	logic [COUNT_W-1:0]        found_index_q;

	// Entry count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_write) begin
			count_q <= cfg_data;
		end
	end

	// A count above the table depth covers the whole table.
	assign count_sat = (count_q > MAX_COUNT) ? MAX_COUNT : count_q;

	// Floor midpoint; both bounds are non-negative whenever a probe is made.
	assign bound_sum = lo_q + hi_q;
	assign mid       = bound_sum[INDEX_W:1];

	// Table storage: loads write, probes read the midpoint.
	sbs_ram #(
		.WIDTH(DATA_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (cmd.load),
		.waddr(entry_index),
		.wdata(entry_value),
		.re   (cmd.read),
		.raddr(mid),
		.rdata(rd_data)
	);

	// Search bounds, key and probed index.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= search_key;
			lo_q  <= '0;
			hi_q  <= $signed({1'b0, count_sat}) - BOUND_W'(1);
		end else if (cmd.step_lo) begin
			lo_q <= $signed({2'b00, mid_q}) + BOUND_W'(1);
		end else if (cmd.step_hi) begin
			hi_q <= $signed({2'b00, mid_q}) - BOUND_W'(1);
		end
		if (cmd.read) begin
			mid_q <= mid;
		end
	end

	// Status toward the controller.
	assign stat.range_empty = (lo_q > hi_q);
	assign stat.key_eq      = (key_q == $signed(rd_data));
	assign stat.key_lt      = (key_q < $signed(rd_data));

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.take_found) begin
			found_q       <= 1'b1;
			found_index_q <= {1'b0, mid_q};
		end else if (cmd.take_miss) begin
			found_q       <= 1'b0;
			found_index_q <= NOT_FOUND_INDEX;
		end
	end

	assign found       = found_q;
	assign found_index = $signed(found_index_q);

endmodule

@@ sim/search_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table lookup checker
// Watches the word and result channels of the binary search block. It keeps
// its own copy of the table and of the entry count, works out the answer of
// every accepted search and compares it with the result the block returns.
// ----------------------------------------------------------------------------
module search_result_checker
	import sbs_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [COUNT_W-1:0]        cfg_data,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      action,
	input  logic [INDEX_W-1:0]        entry_index,
	input  logic signed [DATA_W-1:0]  entry_value,
	input  logic signed [DATA_W-1:0]  search_key,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic                      found,
	input  logic signed [COUNT_W-1:0] found_index,
	output int                        pending,
	output int                        errors
);

	typedef struct packed {
		logic                      hit;
		logic signed [COUNT_W-1:0] slot;
	} lookup_t;

	logic signed [DATA_W-1:0] stored_values [TABLE_DEPTH];
	logic [COUNT_W-1:0]       entries_in_use;
	lookup_t                  expected_lookups [$];
	lookup_t                  want;
	int                       mismatches = 0;

	// Floor-midpoint binary search over the covered part of the table.
	function automatic lookup_t binary_lookup(input logic signed [DATA_W-1:0] key);
		lookup_t answer;
		int      lo;
		int      hi;
		int      mid;
		answer.hit  = 1'b0;
		answer.slot = NOT_FOUND_INDEX;
		lo = 0;
		hi = (entries_in_use > TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(entries_in_use) - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (key == stored_values[mid]) begin
				answer.hit  = 1'b1;
				answer.slot = COUNT_W'(mid);
				return answer;
			end
			if (key < stored_values[mid])
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		return answer;
	endfunction

	// Counts a wrong field and prints the first few of them.
	task automatic note_mismatch(input string field, input int expected_value,
			input int actual_value);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field,
				expected_value, actual_value);
	endtask

	// Results are retired before new words are taken, so a result can never be
	// matched against a search that was accepted in the same cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use = '0;
			expected_lookups.delete();
			pending <= 0;
			errors  <= mismatches;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_lookups.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result: found=%0b found_index=%0d",
							$realtime, found, found_index);
				end else begin
					want = expected_lookups.pop_front();
					if (found !== want.hit)
						note_mismatch("found", want.hit, found);
					if (found_index !== want.slot)
						note_mismatch("found_index", want.slot, found_index);
				end
			end
			if (cfg_write)
				entries_in_use = cfg_data;
			if (in_valid && in_ready) begin
				if (action == ACT_SEARCH)
					expected_lookups.push_back(binary_lookup(search_key));
				else
					stored_values[entry_index] = entry_value;
			end
			pending <= expected_lookups.size();
			errors  <= mismatches;
		end
	end

endmodule

@@ sim/sorted_table_binary_search_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table binary search testbench
// Loads ascending tables of signed values, sets the entry count between
// phases and sends searches for present, neighboring and random keys, with
// random gaps on both channels. The checker beside the block predicts and
// compares every result; this module only drives words and gives the verdict.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_tb;
	import sbs_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int ITEM_TARGET    = 1800;
	// Margin for the longest search: eleven probes plus the hand-off.
	localparam int SEARCH_CYCLES  = 24;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	typedef struct {
		int                       slot;
		logic signed [DATA_W-1:0] value;
	} saved_entry_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_write;
	logic [COUNT_W-1:0]        cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic                      action;
	logic [INDEX_W-1:0]        entry_index;
	logic signed [DATA_W-1:0]  entry_value;
	logic signed [DATA_W-1:0]  search_key;
	logic                      out_valid;
	logic                      out_ready;
	logic                      found;
	logic signed [COUNT_W-1:0] found_index;

	int pending;
	int errors;
	int idle_cycles;
	int sent = 0;
	int active_count = 0;
	bit calm = 1'b0;

	// What the stimulus believes the table holds, used to aim keys.
	logic signed [DATA_W-1:0] shadow [TABLE_DEPTH];
	logic signed [DATA_W-1:0] fresh [TABLE_DEPTH];
	saved_entry_t             overwritten [$];
	int                       preset_counts [6] = '{1024, 2047, 1025, 0, 2, 1023};

	sorted_table_binary_search uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.search_key  (search_key),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.found_index (found_index)
	);

	search_result_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.search_key  (search_key),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.found_index (found_index),
		.pending     (pending),
		.errors      (errors)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Gap before a word or a result; calm phases run back to back.
	function automatic int pause_len();
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	// Uniform value in [lo, hi], computed wide so no span overflows.
	function automatic logic signed [DATA_W-1:0] value_between(input longint lo,
			input longint hi);
		longint span;
		span = hi - lo + 1;
		return DATA_W'(lo + longint'({$urandom, $urandom} % span));
	endfunction

	// Mostly keys that sit in the covered range or right beside an entry.
	function automatic logic signed [DATA_W-1:0] pick_key(input int span);
		int n;
		int pick;
		int mode;
		n    = (span > TABLE_DEPTH) ? TABLE_DEPTH : span;
		mode = $urandom_range(0, 19);
		if (n == 0 || mode < 4)
			return $urandom;
		pick = $urandom_range(0, n - 1);
		if (mode < 7)
			return shadow[pick] + 1;
		if (mode < 10)
			return shadow[pick] - 1;
		if (mode == 10)
			return VALUE_MIN;
		if (mode == 11)
			return VALUE_MAX;
		return shadow[pick];
	endfunction

	// Presents one word and holds it until the block takes it.
	task automatic send_word(input logic act, input logic [INDEX_W-1:0] slot,
			input logic signed [DATA_W-1:0] value, input logic signed [DATA_W-1:0] key);
		int gap;
		gap = pause_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		entry_index <= slot;
		entry_value <= value;
		search_key  <= key;
		sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic load_entry(input int slot, input logic signed [DATA_W-1:0] value);
		shadow[slot] = value;
		send_word(ACT_LOAD, INDEX_W'(slot), value, $urandom);
	endtask

	task automatic search_for(input logic signed [DATA_W-1:0] key);
		send_word(ACT_SEARCH, INDEX_W'($urandom), $urandom, key);
	endtask

	// Stops sending and lets every outstanding search finish.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SEARCH_CYCLES) @(posedge clk);
	endtask

	task automatic set_entries_in_use(input int span);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_data  <= COUNT_W'(span);
		@(posedge clk);
		cfg_write <= 1'b0;
		active_count = span;
	endtask

	// Result side: a random stall before each result, held until it is taken.
	initial begin
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			int gap;
			gap = pause_len();
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Ends a hung run: too long without any word or result moving.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int           p;
		int           k;
		int           phase_len;
		int           slot;
		int           hot;
		int           next_count;
		bit           scrambled;
		longint       level;
		saved_entry_t rec;

		arst_n      <= 1'b0;
		cfg_write   <= 1'b0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		action      <= ACT_LOAD;
		entry_index <= '0;
		entry_value <= '0;
		search_key  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table after reset: every search misses.
		search_for(32'sd0);
		search_for(VALUE_MIN);

		// Small table with both extremes and runs of duplicates.
		load_entry(0, VALUE_MIN);
		load_entry(1, -32'sd5);
		load_entry(2, -32'sd5);
		load_entry(3, 32'sd0);
		load_entry(4, 32'sd7);
		load_entry(5, 32'sd7);
		load_entry(6, 32'sd7);
		load_entry(7, VALUE_MAX);
		set_entries_in_use(8);
		search_for(VALUE_MIN);
		search_for(VALUE_MAX);
		search_for(-32'sd5);
		search_for(32'sd7);
		search_for(32'sd0);
		search_for(32'sd1);
		search_for(-32'sd6);
		search_for(32'sd8);
		search_for(VALUE_MIN + 1);
		search_for(VALUE_MAX - 1);

		// A single entry covered.
		set_entries_in_use(1);
		search_for(VALUE_MIN);
		search_for(-32'sd5);

		// Fill the whole table in ascending order, searching the first eight
		// entries while they are rewritten.
		set_entries_in_use(8);
		level = VALUE_MAX;
		for (k = TABLE_DEPTH - 1; k >= 0; k--) begin
			fresh[k] = DATA_W'(level);
			if ($urandom_range(0, 3) != 0)
				level -= $urandom_range(1, 8000000);
		end
		for (k = 0; k < TABLE_DEPTH; k++) begin
			load_entry(k, fresh[k]);
			if ($urandom_range(0, 3) == 0)
				search_for(pick_key(active_count));
		end

		// Random phases: a new count, then a mix of searches and loads. Loads
		// keep the table sorted, except in scrambled phases, which write noise
		// and put the old values back before the phase ends.
		p = 0;
		while (sent < ITEM_TARGET) begin
			if (p < 6) begin
				next_count = preset_counts[p];
			end else begin
				case ($urandom_range(0, 9))
					8: next_count = $urandom_range(TABLE_DEPTH + 1, 2047);
					9: next_count = $urandom_range(0, 1);
					6, 7: next_count = $urandom_range(65, TABLE_DEPTH);
					default: next_count = $urandom_range(1, 64);
				endcase
			end
			set_entries_in_use(next_count);
			calm      = ($urandom_range(0, 3) == 0);
			scrambled = ($urandom_range(0, 5) == 0);
			hot       = (next_count == 0) ? TABLE_DEPTH - 1
				: ((next_count > TABLE_DEPTH) ? TABLE_DEPTH - 1 : next_count - 1);
			phase_len = $urandom_range(20, 60);
			for (k = 0; k < phase_len; k++) begin
				if ($urandom_range(0, 4) != 0) begin
					search_for(pick_key(active_count));
				end else if (scrambled) begin
					slot = $urandom_range(0, hot);
					overwritten.push_back('{slot, shadow[slot]});
					load_entry(slot, $urandom);
				end else begin
					slot = $urandom_range(0, TABLE_DEPTH - 1);
					load_entry(slot, value_between(
						(slot == 0) ? VALUE_MIN : shadow[slot - 1],
						(slot == TABLE_DEPTH - 1) ? VALUE_MAX : shadow[slot + 1]));
				end
			end
			while (overwritten.size() > 0) begin
				rec = overwritten.pop_back();
				load_entry(rec.slot, rec.value);
			end
			p++;
		end

		wait_idle();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
